// ----- rtl/core/ray_segment_nearest_hit_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the ray segment nearest hit unit
// Implication checks on the unit's clock, switched off for synthesis.
// ----------------------------------------------------------------------------
`ifndef RAY_SEGMENT_NEAREST_HIT_UNIT_MACROS_SVH
`define RAY_SEGMENT_NEAREST_HIT_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RSNH_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rsnh assertion failed");
// next-cycle implication
`define RSNH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rsnh assertion failed");
`else
`define RSNH_ASSERT_NOW(label, clk, rst, ante, cons)
`define RSNH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/core/rsnh_pkg.sv -----
// ----------------------------------------------------------------------------
// rsnh_pkg
// Types and constants shared by the ray segment nearest hit unit.
// ----------------------------------------------------------------------------
package rsnh_pkg;

   localparam int MAX_WALLS = 64;
   localparam int ADDR_W    = $clog2(MAX_WALLS);
   localparam int CNT_W     = $clog2(MAX_WALLS + 1);
   localparam int WALL_W    = 64;

   // arithmetic widths
   localparam int DIR_W  = 28;   // ray length * dir, 14 fraction bits
   localparam int VEC_W  = 17;   // coordinate differences
   localparam int PROD_W = DIR_W + VEC_W;
   localparam int DET_W  = PROD_W + 1;
   localparam int DIST_W = 15;
   localparam int DIV_STEPS = DIST_W;
   localparam int NUM_W  = DET_W + DIST_W - 1;

   // register indexes
   localparam logic REG_CAST_LEN   = 1'b0;
   localparam logic REG_WALL_COUNT = 1'b1;

   // modes
   localparam logic MODE_WALL = 1'b0;
   localparam logic MODE_RAY  = 1'b1;

   typedef struct packed {
      logic               mode;
      logic [5:0]         wall_index;
      logic signed [15:0] wall_x1;
      logic signed [15:0] wall_y1;
      logic signed [15:0] wall_x2;
      logic signed [15:0] wall_y2;
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
      logic signed [15:0] dir_cos;
      logic signed [15:0] dir_sin;
   } req_type;

   typedef struct packed {
      logic [14:0] distance;
      logic        hit;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] y2;
      logic signed [15:0] x2;
      logic signed [15:0] y1;
      logic signed [15:0] x1;
   } wall_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

endpackage

// ----- rtl/core/rsnh_ram.sv -----
// ----------------------------------------------------------------------------
// rsnh_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rsnh_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/ray_segment_nearest_hit_unit.sv -----
// ----------------------------------------------------------------------------
// ray_segment_nearest_hit_unit
// Casts a ray against a table of wall segments and returns the nearest hit.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req_data): mode 0 writes one wall
//   entry into the wall RAM and gives no response; mode 1 casts a ray.
//   rsp channel (rsp_valid / rsp_stall / rsp_data): one transfer per ray,
//   carrying the distance in Q11.4 and the hit flag.
//   csr port: ray length (index 0) and wall_count (index 1), written while
//   the unit is idle.
// Timing:
//   A ray reads one wall per cycle from the single RAM read port; its
//   response is valid after the RAM read, five arithmetic stages, 15 divider
//   steps and the running minimum behind the scan, then the response register,
//   or after the response register alone with no walls. The next request is
//   taken in the cycle after the response loads.
// Reset clears the control state and sets the ray length to 1024 and
// wall_count to 0; the wall table is undefined until written. While rsp is
// stalled the finished ray holds the response register; the next ray may
// already be accepted and waits at its end until the response register is free.
// ----------------------------------------------------------------------------
`include "ray_segment_nearest_hit_unit_macros.svh"

module ray_segment_nearest_hit_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  rsnh_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsnh_pkg::rsp_type   rsp_data,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [10:0]         csr_wdata
);

   localparam int DW = rsnh_pkg::DIR_W;
   localparam int VW = rsnh_pkg::VEC_W;
   localparam int PW = rsnh_pkg::PROD_W;
   localparam int TW = rsnh_pkg::DET_W;
   localparam int NW = rsnh_pkg::NUM_W;
   localparam int QW = rsnh_pkg::DIST_W;
   localparam int KS = rsnh_pkg::DIV_STEPS;
   localparam int CW = rsnh_pkg::CNT_W;
   localparam int AW = rsnh_pkg::ADDR_W;

   // configuration registers
   logic [10:0] cast_len_ff;
   logic [6:0]  wall_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cast_len_ff   <= 11'd1024;
         wall_count_ff <= 7'd0;
      end else if (csr_we) begin
         case (csr_index)
            rsnh_pkg::REG_CAST_LEN:   cast_len_ff   <= csr_wdata;
            rsnh_pkg::REG_WALL_COUNT: wall_count_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // walls in use, saturated at table depth
   logic [CW-1:0] wall_num;
   always_comb begin
      if (32'(wall_count_ff) > rsnh_pkg::MAX_WALLS) wall_num = CW'(rsnh_pkg::MAX_WALLS);
      else wall_num = CW'(wall_count_ff);
   end

   // sequencer
   rsnh_pkg::state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] num_ff, num_in;
   logic          req_xfer, ray_xfer, wall_xfer;
   logic          rd_en;
   logic          pipe_busy;
   logic          out_free;
   logic          rsp_load;

   assign req_stall = (state_ff != rsnh_pkg::ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign ray_xfer  = req_xfer && (req_data.mode == rsnh_pkg::MODE_RAY);
   assign wall_xfer = req_xfer && (req_data.mode == rsnh_pkg::MODE_WALL);
   assign out_free  = !rsp_valid || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      num_in   = num_ff;
      rd_en    = 1'b0;
      rsp_load = 1'b0;
      case (state_ff)
         rsnh_pkg::ST_IDLE: begin
            if (ray_xfer) begin
               cnt_in   = '0;
               num_in   = wall_num;
               state_in = (wall_num == '0) ? rsnh_pkg::ST_DRAIN : rsnh_pkg::ST_SCAN;
            end
         end
         rsnh_pkg::ST_SCAN: begin
            rd_en  = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == num_ff - 1'b1) begin
               state_in = rsnh_pkg::ST_DRAIN;
            end
         end
         rsnh_pkg::ST_DRAIN: begin
            if (!pipe_busy && out_free) begin
               rsp_load = 1'b1;
               state_in = rsnh_pkg::ST_IDLE;
            end
         end
         default: state_in = rsnh_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rsnh_pkg::ST_IDLE;
         cnt_ff   <= '0;
         num_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         num_ff   <= num_in;
      end
   end

   // ray parameters, held for the whole scan
   logic signed [DW-1:0] dx_ff, dy_ff;
   logic signed [15:0]   ox_ff, oy_ff;
   logic [QW-1:0]        full_ff;

   always_ff @(posedge clock) begin
      if (ray_xfer) begin
         dx_ff   <= $signed({1'b0, cast_len_ff}) * req_data.dir_cos;
         dy_ff   <= $signed({1'b0, cast_len_ff}) * req_data.dir_sin;
         ox_ff   <= req_data.origin_x;
         oy_ff   <= req_data.origin_y;
         full_ff <= {cast_len_ff, 4'b0000};
      end
   end

   // wall table
   rsnh_pkg::wall_type wr_wall, rd_wall;
   logic [rsnh_pkg::WALL_W-1:0] rd_word;
   logic wr_en;

   assign wr_wall.x1 = req_data.wall_x1;
   assign wr_wall.y1 = req_data.wall_y1;
   assign wr_wall.x2 = req_data.wall_x2;
   assign wr_wall.y2 = req_data.wall_y2;
   assign wr_en      = wall_xfer && (32'(req_data.wall_index) < rsnh_pkg::MAX_WALLS);
   assign rd_wall    = rd_word;

   rsnh_ram #(
      .WIDTH (rsnh_pkg::WALL_W),
      .DEPTH (rsnh_pkg::MAX_WALLS)
   ) u_wall_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_data.wall_index)),
      .wr_data (wr_wall),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff[AW-1:0]),
      .rd_data (rd_word)
   );

   // pipeline valid bits
   logic rd_v_ff, s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;
   logic div_v_ff [KS+1];

   // stage 1: wall and offset vectors
   logic signed [VW-1:0] ex_ff, ey_ff, wx_ff, wy_ff;
   always_ff @(posedge clock) begin
      ex_ff <= VW'(rd_wall.x2) - VW'(rd_wall.x1);
      ey_ff <= VW'(rd_wall.y2) - VW'(rd_wall.y1);
      wx_ff <= VW'(ox_ff) - VW'(rd_wall.x1);
      wy_ff <= VW'(oy_ff) - VW'(rd_wall.y1);
   end

   // stage 2: cross products
   logic signed [PW-1:0] p_dey_ff, p_dex_ff, p_wyex_ff, p_wxey_ff, p_wydx_ff, p_wxdy_ff;
   always_ff @(posedge clock) begin
      p_dey_ff  <= dx_ff * ey_ff;
      p_dex_ff  <= dy_ff * ex_ff;
      p_wyex_ff <= wy_ff * ex_ff;
      p_wxey_ff <= wx_ff * ey_ff;
      p_wydx_ff <= wy_ff * dx_ff;
      p_wxdy_ff <= wx_ff * dy_ff;
   end

   // stage 3: determinant and numerators at 18 fraction bits
   logic signed [TW-1:0] den_ff, tn_ff, un_ff;
   always_ff @(posedge clock) begin
      den_ff <= TW'(p_dey_ff) - TW'(p_dex_ff);
      tn_ff  <= (TW'(p_wyex_ff) - TW'(p_wxey_ff)) <<< 10;
      un_ff  <= TW'(p_wydx_ff) - TW'(p_wxdy_ff);
   end

   // stage 4: make the determinant positive
   logic signed [TW-1:0] nden_ff, ntn_ff, nun_ff;
   logic                 nz_ff;
   always_ff @(posedge clock) begin
      nz_ff <= (den_ff != '0);
      if (den_ff < 0) begin
         nden_ff <= -den_ff;
         ntn_ff  <= -tn_ff;
         nun_ff  <= -un_ff;
      end else begin
         nden_ff <= den_ff;
         ntn_ff  <= tn_ff;
         nun_ff  <= un_ff;
      end
   end

   // stage 5: range check and numerator scaled by full length
   logic s5_ok;
   assign s5_ok = nz_ff && !ntn_ff[TW-1] && (ntn_ff <= nden_ff)
                  && !nun_ff[TW-1] && (nun_ff <= nden_ff);

   // divider: one quotient bit per stage, most significant first
   logic [NW-1:0]   div_rem_ff [KS+1];
   logic [TW-2:0]   div_den_ff [KS+1];
   logic [QW-1:0]   div_q_ff   [KS+1];

   always_ff @(posedge clock) begin
      div_rem_ff[0] <= NW'(ntn_ff[TW-2:0]) * NW'(full_ff);
      div_den_ff[0] <= nden_ff[TW-2:0];
      div_q_ff[0]   <= '0;
   end

   for (genvar j = 0; j < KS; j++) begin : g_div
      logic [NW-1:0] trial;
      assign trial = NW'(div_den_ff[j]) << (KS - 1 - j);
      always_ff @(posedge clock) begin
         div_den_ff[j+1] <= div_den_ff[j];
         if (div_rem_ff[j] >= trial) begin
            div_rem_ff[j+1] <= div_rem_ff[j] - trial;
            div_q_ff[j+1]   <= {div_q_ff[j][QW-2:0], 1'b1};
         end else begin
            div_rem_ff[j+1] <= div_rem_ff[j];
            div_q_ff[j+1]   <= {div_q_ff[j][QW-2:0], 1'b0};
         end
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         for (int k = 0; k <= KS; k++) begin
            div_v_ff[k] <= 1'b0;
         end
      end else begin
         rd_v_ff     <= rd_en;
         s1_v_ff     <= rd_v_ff;
         s2_v_ff     <= s1_v_ff;
         s3_v_ff     <= s2_v_ff;
         s4_v_ff     <= s3_v_ff;
         div_v_ff[0] <= s4_v_ff && s5_ok;
         for (int k = 0; k < KS; k++) begin
            div_v_ff[k+1] <= div_v_ff[k];
         end
      end
   end

   always_comb begin
      pipe_busy = rd_v_ff || s1_v_ff || s2_v_ff || s3_v_ff || s4_v_ff;
      for (int k = 0; k <= KS; k++) begin
         pipe_busy = pipe_busy || div_v_ff[k];
      end
   end

   // running minimum of the distance
   logic [QW-1:0] best_ff;
   always_ff @(posedge clock) begin
      if (ray_xfer) begin
         best_ff <= {cast_len_ff, 4'b0000};
      end else if (div_v_ff[KS] && (div_q_ff[KS] < best_ff)) begin
         best_ff <= div_q_ff[KS];
      end
   end

   // response register
   logic             rsp_valid_ff;
   rsnh_pkg::rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff.distance <= best_ff;
         rsp_ff.hit      <= (best_ff < full_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `RSNH_ASSERT_NOW(a_req_only_idle, clock, reset, req_xfer, state_ff == rsnh_pkg::ST_IDLE)
   `RSNH_ASSERT_NOW(a_quot_in_range, clock, reset, div_v_ff[KS], div_q_ff[KS] <= full_ff)
   `RSNH_ASSERT_NOW(a_no_read_idle, clock, reset, rd_en, state_ff == rsnh_pkg::ST_SCAN)
   `RSNH_ASSERT_NEXT(a_load_shows, clock, reset, rsp_load, rsp_valid_ff)

endmodule

// ----- tb/sv/ray_segment_nearest_hit_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_segment_nearest_hit_unit_tb
// Self-checking bench for the ray against wall table unit. A directed table
// covers the empty table, the extreme coordinates, a zero length ray, a zero
// direction and a wall exactly at the ray end. Random phases then mix wall
// writes and rays under four idle patterns, one with a saturated wall count.
// Rays with no fixed result are checked against an exact integer model.
// ----------------------------------------------------------------------------
module ray_segment_nearest_hit_unit_tb;

   localparam int SETTLE_CYCLES = 120;     // longer than one ray takes at 64 walls
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_ITEMS   = 70;

   typedef enum logic { ROW_XFER, ROW_REG } row_kind_type;

   typedef struct {
      row_kind_type      kind;
      rsnh_pkg::req_type req;
      logic              reg_idx;
      logic [10:0]       reg_val;
      bit                typed;
      rsnh_pkg::rsp_type want;
   } stim_row_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   rsnh_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   rsnh_pkg::rsp_type rsp_data;
   logic              csr_we;
   logic              csr_index;
   logic [10:0]       csr_wdata;

   // model state
   rsnh_pkg::wall_type wall_mem [rsnh_pkg::MAX_WALLS];
   bit                 wall_written [rsnh_pkg::MAX_WALLS];
   logic [10:0]        ray_len;
   logic [6:0]         walls_used;

   rsnh_pkg::rsp_type pending_hits [$];
   stim_row_type      stim_rows [$];
   int          fail_count;
   int          cycle_count;
   int          send_idle_pct;
   int          stall_pct;
   int          rays_checked;
   int          hits_seen;
   int          walls_sent;

   ray_segment_nearest_hit_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // nearest hit over the active walls, exact integer arithmetic
   function automatic rsnh_pkg::rsp_type nearest_hit(input rsnh_pkg::req_type r);
      longint len, ox, oy, dx, dy, full, best, n;
      longint ax, ay, ex, ey, wx, wy, den, tn, un, d;
      rsnh_pkg::rsp_type res;
      len  = longint'(ray_len);
      ox   = longint'(r.origin_x);
      oy   = longint'(r.origin_y);
      dx   = len * longint'(r.dir_cos);
      dy   = len * longint'(r.dir_sin);
      full = len * 16;
      best = full;
      n    = (walls_used > rsnh_pkg::MAX_WALLS) ? rsnh_pkg::MAX_WALLS
                                                : longint'(walls_used);
      for (int i = 0; i < n; i++) begin
         ax  = longint'(wall_mem[i].x1);
         ay  = longint'(wall_mem[i].y1);
         ex  = longint'(wall_mem[i].x2) - ax;
         ey  = longint'(wall_mem[i].y2) - ay;
         wx  = ox - ax;
         wy  = oy - ay;
         den = dx * ey - dy * ex;
         tn  = (wy * ex - wx * ey) * 1024;
         un  = wy * dx - wx * dy;
         if (den == 0) continue;
         if (den < 0) begin
            den = -den;
            tn  = -tn;
            un  = -un;
         end
         if (tn < 0 || tn > den || un < 0 || un > den) continue;
         d = (tn * full) / den;
         if (d < best) best = d;
      end
      res.distance = best[14:0];
      res.hit      = (best < full);
      return res;
   endfunction

   function automatic rsnh_pkg::req_type wall_req(input int idx, input int x1, input int y1,
                                                  input int x2, input int y2);
      rsnh_pkg::req_type r;
      r            = '0;
      r.mode       = rsnh_pkg::MODE_WALL;
      r.wall_index = idx[5:0];
      r.wall_x1    = x1[15:0];
      r.wall_y1    = y1[15:0];
      r.wall_x2    = x2[15:0];
      r.wall_y2    = y2[15:0];
      return r;
   endfunction

   function automatic rsnh_pkg::req_type ray_req(input int ox, input int oy,
                                                 input int dc, input int ds);
      rsnh_pkg::req_type r;
      r          = '0;
      r.mode     = rsnh_pkg::MODE_RAY;
      r.origin_x = ox[15:0];
      r.origin_y = oy[15:0];
      r.dir_cos  = dc[15:0];
      r.dir_sin  = ds[15:0];
      return r;
   endfunction

   task automatic add_xfer(input rsnh_pkg::req_type r, input bit typed,
                           input rsnh_pkg::rsp_type want);
      stim_row_type row;
      row.kind    = ROW_XFER;
      row.req     = r;
      row.reg_idx = 1'b0;
      row.reg_val = '0;
      row.typed   = typed;
      row.want    = want;
      stim_rows.push_back(row);
   endtask

   task automatic add_reg(input logic idx, input int val);
      stim_row_type row;
      row.kind    = ROW_REG;
      row.req     = '0;
      row.reg_idx = idx;
      row.reg_val = val[10:0];
      row.typed   = 1'b0;
      row.want    = '0;
      stim_rows.push_back(row);
   endtask

   // one transfer on the request side, with a random gap ahead of it
   task automatic send_req(input rsnh_pkg::req_type r, input bit typed,
                           input rsnh_pkg::rsp_type want);
      int gap;
      gap = 0;
      while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      if (r.mode == rsnh_pkg::MODE_WALL) begin
         wall_mem[r.wall_index].x1 = r.wall_x1;
         wall_mem[r.wall_index].y1 = r.wall_y1;
         wall_mem[r.wall_index].x2 = r.wall_x2;
         wall_mem[r.wall_index].y2 = r.wall_y2;
         wall_written[r.wall_index] = 1'b1;
         walls_sent++;
      end else begin
         pending_hits.push_back(typed ? want : nearest_hit(r));
      end
   endtask

   // wait for every outstanding response, then let the pipeline settle
   task automatic drain_all();
      req_valid <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one register write, then the write port is left idle before returning
   task automatic write_reg(input logic idx, input logic [10:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == rsnh_pkg::REG_CAST_LEN) ray_len = val;
      else walls_used = val[6:0];
      @(posedge clock);
   endtask

   function automatic int rand_coord(input int span);
      return $urandom_range(2 * span) - span;
   endfunction

   function automatic rsnh_pkg::req_type rand_wall(input int idx);
      if ($urandom_range(99) < 15)
         return wall_req(idx, $urandom, $urandom, $urandom, $urandom);
      return wall_req(idx, rand_coord(8192), rand_coord(8192),
                      rand_coord(8192), rand_coord(8192));
   endfunction

   function automatic rsnh_pkg::req_type rand_ray();
      real ang;
      if ($urandom_range(99) < 15)
         return ray_req($urandom, $urandom, $urandom_range(32768) - 16384,
                        $urandom_range(32768) - 16384);
      ang = $urandom_range(62831) / 10000.0;
      return ray_req(rand_coord(4096), rand_coord(4096),
                     $rtoi($cos(ang) * 16384.0), $rtoi($sin(ang) * 16384.0));
   endfunction

   // response side: random stall and in-order compare
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      rsnh_pkg::rsp_type exp_hit;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_hits.size() == 0) begin
            $display("%0t: unexpected response distance=%0d hit=%0b", $time,
                     rsp_data.distance, rsp_data.hit);
            fail_count++;
         end else begin
            exp_hit = pending_hits.pop_front();
            rays_checked++;
            if (rsp_data.hit) hits_seen++;
            if (rsp_data.distance !== exp_hit.distance) begin
               $display("%0t: distance expected %0d actual %0d", $time,
                        exp_hit.distance, rsp_data.distance);
               fail_count++;
            end
            if (rsp_data.hit !== exp_hit.hit) begin
               $display("%0t: hit expected %0b actual %0b", $time,
                        exp_hit.hit, rsp_data.hit);
               fail_count++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      int                len_sel [6];
      int                cnt_sel [6];
      int                idle_sel [6];
      int                cnt;
      rsnh_pkg::rsp_type no_hit;
      rsnh_pkg::rsp_type zero_len;
      rsnh_pkg::req_type r;

      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_data      <= '0;
      csr_we        <= 1'b0;
      csr_index     <= rsnh_pkg::REG_CAST_LEN;
      csr_wdata     <= '0;
      fail_count    = 0;
      cycle_count   = 0;
      send_idle_pct = 0;
      stall_pct     = 0;
      rays_checked  = 0;
      hits_seen     = 0;
      walls_sent    = 0;
      ray_len       = 11'd1024;
      walls_used    = 7'd0;
      for (int i = 0; i < rsnh_pkg::MAX_WALLS; i++) begin
         wall_mem[i]     = '0;
         wall_written[i] = 1'b0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed table
      no_hit.distance   = 15'd16384;
      no_hit.hit        = 1'b0;
      zero_len.distance = 15'd0;
      zero_len.hit      = 1'b0;
      add_xfer(ray_req(0, 0, 16384, 0), 1'b1, no_hit);          // empty table
      add_xfer(wall_req(0, 16384, -1600, 16384, 1600), 1'b0, '0); // at ray end
      add_xfer(wall_req(1, 1600, -1600, 1600, 1600), 1'b0, '0);
      add_xfer(wall_req(2, -32768, -32768, 32767, 32767), 1'b0, '0);
      add_xfer(wall_req(3, -32768, 800, 32767, 800), 1'b0, '0);   // parallel
      add_xfer(wall_req(63, -1600, -1600, -1600, 1600), 1'b0, '0);
      add_reg(rsnh_pkg::REG_WALL_COUNT, 1);
      add_xfer(ray_req(0, 0, 16384, 0), 1'b1, no_hit);          // t exactly 1
      add_reg(rsnh_pkg::REG_WALL_COUNT, 4);
      add_xfer(ray_req(0, 0, 16384, 0), 1'b0, '0);
      add_xfer(ray_req(0, 0, 0, 0), 1'b1, no_hit);              // zero direction
      add_xfer(ray_req(0, 0, -16384, 0), 1'b0, '0);
      add_xfer(ray_req(100, -50, 16384, 16384), 1'b0, '0);      // non-unit
      add_xfer(ray_req(0, 0, 0, -16384), 1'b0, '0);
      add_xfer(ray_req(32767, -32768, -16384, 16384), 1'b0, '0);
      add_xfer(ray_req(-32768, 32767, 16384, -16384), 1'b0, '0);
      add_reg(rsnh_pkg::REG_CAST_LEN, 0);
      add_xfer(ray_req(0, 0, 16384, 0), 1'b1, zero_len);        // zero length
      add_reg(rsnh_pkg::REG_CAST_LEN, 2047);
      add_xfer(ray_req(-200, 300, 11585, -11585), 1'b0, '0);
      add_xfer(ray_req(0, 0, 16384, 0), 1'b0, '0);

      foreach (stim_rows[k]) begin
         if (stim_rows[k].kind == ROW_REG) begin
            drain_all();
            write_reg(stim_rows[k].reg_idx, stim_rows[k].reg_val);
         end else begin
            send_req(stim_rows[k].req, stim_rows[k].typed, stim_rows[k].want);
         end
      end

      // random phases: ray length, wall count and idle pattern per phase
      len_sel  = '{2047, 1, -1, -1, 1024, -1};
      cnt_sel  = '{64, 1, 127, -1, 0, -1};
      idle_sel = '{0, 1, 2, 3, 0, 3};
      for (int p = 0; p < 6; p++) begin
         drain_all();
         cnt = (cnt_sel[p] < 0) ? $urandom_range(64) : cnt_sel[p];
         send_idle_pct = 0;
         stall_pct     = 0;
         // every entry under the count must hold a wall before it is read
         for (int i = 0; i < rsnh_pkg::MAX_WALLS && i < cnt; i++)
            if (!wall_written[i]) send_req(rand_wall(i), 1'b0, '0);
         drain_all();
         write_reg(rsnh_pkg::REG_CAST_LEN,
                   11'((len_sel[p] < 0) ? $urandom_range(1, 2047) : len_sel[p]));
         write_reg(rsnh_pkg::REG_WALL_COUNT, 11'(cnt));
         send_idle_pct = (idle_sel[p] == 1) ? 50 : (idle_sel[p] == 3) ? 21 : 0;
         stall_pct     = (idle_sel[p] == 2) ? 50 : (idle_sel[p] == 3) ? 21 : 0;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 2 && k == PHASE_ITEMS / 2) begin
               // hold the sender until all rays are back
               req_valid <= 1'b0;
               do @(posedge clock); while (pending_hits.size() != 0);
            end
            if ($urandom_range(99) < 25)
               r = rand_wall($urandom_range(rsnh_pkg::MAX_WALLS - 1));
            else
               r = rand_ray();
            send_req(r, 1'b0, '0);
         end
      end

      drain_all();
      $display("covered %0d rays (%0d hits) and %0d wall writes", rays_checked,
               hits_seen, walls_sent);
      $display("ray lengths 0 to 2047, wall counts 0 to 127, four idle patterns");
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/rsnh_pkg.sv
rtl/core/rsnh_ram.sv
rtl/core/ray_segment_nearest_hit_unit.sv
tb/sv/ray_segment_nearest_hit_unit_tb.sv
